/* rtl/core/fbp_pkg.sv */
// Shared types, codes and constants of the frame buffer pool manager.
package fbp_pkg;

  localparam int ID_W           = 6;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;
  localparam int CNT_W          = 7;
  localparam int FSTATE_W       = 3;
  localparam int DEF_POOL_DEPTH = 64;
  localparam int RESET_FRAMES   = 16;

  localparam logic [CNT_W-1:0] RESET_FRAME_COUNT = CNT_W'(RESET_FRAMES);

  // Operation codes on the request channel
  localparam logic [OP_W-1:0] OP_REQUEST     = 3'd0;
  localparam logic [OP_W-1:0] OP_RET_DECODED = 3'd1;
  localparam logic [OP_W-1:0] OP_SHARE       = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_DISPLAY = 3'd3;
  localparam logic [OP_W-1:0] OP_RET_DISPLAY = 3'd4;
  localparam logic [OP_W-1:0] OP_FLUSH       = 3'd5;

  typedef enum logic [FSTATE_W-1:0] {
    FS_FREE        = 3'd0,
    FS_DECODING    = 3'd1,
    FS_DISPLAY     = 3'd2,
    FS_SHARED      = 3'd3,
    FS_SHARED_FREE = 3'd4
  } fstate_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_BAD_ID = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    K_REQUEST,
    K_RET_DECODED,
    K_SHARE,
    K_GET_DISPLAY,
    K_RET_DISPLAY,
    K_FLUSH,
    K_BAD_ID,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] id;
    logic            valid_req;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

/* rtl/core/fbp_if.sv */
// Channel interfaces of the frame buffer pool manager: request, response, config.
interface fbp_in_if;
  import fbp_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] frame_id;
  logic            valid_req;
  modport source (output valid, operation, frame_id, valid_req, input ready);
  modport sink   (input valid, operation, frame_id, valid_req, output ready);
endinterface

interface fbp_out_if;
  import fbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     out_frame;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    ready_count;
  modport source (output valid, out_frame, found, status, free_count, ready_count,
                  input ready);
  modport sink   (input valid, out_frame, found, status, free_count, ready_count,
                  output ready);
endinterface

interface fbp_cfg_if;
  import fbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/fbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fbp_front.sv */
// Front end: holds the frame count register, checks ids and classifies requests.
module fbp_front #(
  parameter int POOL_DEPTH = fbp_pkg::DEF_POOL_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  fbp_in_if.sink                          req,
  fbp_cfg_if.sink                         cfg,
  input  logic                            fifo_full,
  output logic                            cmd_push,
  output fbp_pkg::cmd_t                   cmd,
  output logic [$clog2(POOL_DEPTH+1)-1:0] eff_count
);
  import fbp_pkg::*;

  localparam int FW  = $clog2(POOL_DEPTH + 1);
  localparam int CW  = (FW > CNT_W) ? FW : CNT_W;
  localparam int CIW = (FW > ID_W) ? FW : ID_W;

  logic [CNT_W-1:0] frame_count;
  logic [CW-1:0]    cnt_ext;
  logic [CW-1:0]    eff_ext;
  logic             uses_id;
  logic             bad_id;
  kind_t            kind;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= RESET_FRAME_COUNT;
    end else if (cfg.valid) begin
      frame_count <= cfg.data;
    end
  end

  // Clamp the pool size to the storage depth
  assign cnt_ext   = CW'(frame_count);
  assign eff_ext   = (cnt_ext > CW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : cnt_ext;
  assign eff_count = FW'(eff_ext);

  assign bad_id = CIW'(req.frame_id) >= CIW'(eff_count);

  always_comb begin
    uses_id = 1'b0;
    unique case (req.operation)
      OP_REQUEST:     kind = K_REQUEST;
      OP_RET_DECODED: begin
        kind    = K_RET_DECODED;
        uses_id = 1'b1;
      end
      OP_SHARE: begin
        kind    = K_SHARE;
        uses_id = 1'b1;
      end
      OP_GET_DISPLAY: kind = K_GET_DISPLAY;
      OP_RET_DISPLAY: begin
        kind    = K_RET_DISPLAY;
        uses_id = 1'b1;
      end
      OP_FLUSH:       kind = K_FLUSH;
      default:        kind = K_NOP;
    endcase
    if (uses_id && bad_id) begin
      kind = K_BAD_ID;
    end
  end

  assign req.ready     = !fifo_full;
  assign cmd_push      = req.valid && !fifo_full;
  assign cmd.kind      = kind;
  assign cmd.id        = req.frame_id;
  assign cmd.valid_req = req.valid_req;

endmodule

/* rtl/core/fbp_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
module fbp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fbp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          cmd_valid,
  output fbp_pkg::cmd_t head_cmd
);
  import fbp_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign head_cmd  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* rtl/core/fbp_back.sv */
// Back end: frame state and queue memories, command execution and response register.
module fbp_back #(
  parameter int POOL_DEPTH = fbp_pkg::DEF_POOL_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  fbp_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  input  logic [$clog2(POOL_DEPTH+1)-1:0] eff_count,
  fbp_out_if.source                       rsp
);
  import fbp_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int FW = $clog2(POOL_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int RST_FILL = (RESET_FRAMES > POOL_DEPTH) ? POOL_DEPTH : RESET_FRAMES;

  back_state_t bk_state, bk_state_next;
  cmd_t        cur;

  logic [AW-1:0] free_head, free_head_next;
  logic [FW-1:0] free_fill, free_fill_next;
  logic [AW-1:0] disp_head, disp_head_next;
  logic [FW-1:0] disp_fill, disp_fill_next;
  logic [POOL_DEPTH-1:0] st_vld;
  logic [POOL_DEPTH-1:0] fq_vld;

  logic                rsp_valid;
  logic [ID_W-1:0]     rsp_frame;
  logic                rsp_found;
  logic [STATUS_W-1:0] rsp_status;
  logic [CNT_W-1:0]    rsp_free_count;
  logic [CNT_W-1:0]    rsp_ready_count;

  logic                start;
  logic                exec;
  logic                flush;
  logic [ID_W-1:0]     res_frame;
  logic                res_found;
  status_t             res_status;

  logic                st_we;
  logic [AW-1:0]       st_waddr;
  fstate_t             st_wdata;
  logic [FSTATE_W-1:0] st_rdata;
  logic                fq_we;
  logic [AW-1:0]       fq_waddr;
  logic [ID_W-1:0]     fq_rdata;
  logic                dq_we;
  logic [AW-1:0]       dq_waddr;
  logic [ID_W-1:0]     dq_rdata;

  logic [AW-1:0]   cur_idx;
  fstate_t         st_cur;
  logic [ID_W-1:0] fq_head_val;
  logic [SW-1:0]   fq_sum;
  logic [SW-1:0]   dq_sum;
  logic [AW-1:0]   fq_tail;
  logic [AW-1:0]   dq_tail;
  logic            free_full;
  logic            disp_full;
  logic [AW-1:0]   free_head_inc;
  logic [AW-1:0]   disp_head_inc;

  // Memories: read every cycle, write during execution
  fbp_ram #(.WIDTH(FSTATE_W), .DEPTH(POOL_DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (AW'(cmd.id)),
    .rdata (st_rdata)
  );

  fbp_ram #(.WIDTH(ID_W), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (fq_we),
    .waddr (fq_waddr),
    .wdata (cur.id),
    .raddr (free_head),
    .rdata (fq_rdata)
  );

  fbp_ram #(.WIDTH(ID_W), .DEPTH(POOL_DEPTH)) u_disp_ram (
    .clk   (clk),
    .we    (dq_we),
    .waddr (dq_waddr),
    .wdata (cur.id),
    .raddr (disp_head),
    .rdata (dq_rdata)
  );

  // Next state
  always_comb begin
    unique case (bk_state)
      BK_IDLE: bk_state_next = start ? BK_EXEC : BK_IDLE;
      BK_EXEC: bk_state_next = BK_IDLE;
      default: bk_state_next = BK_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    start = 1'b0;
    exec  = 1'b0;
    unique case (bk_state)
      BK_IDLE: start = cmd_valid && (!rsp_valid || rsp.ready);
      BK_EXEC: exec  = 1'b1;
      default: start = 1'b0;
    endcase
  end

  assign cmd_pop = start;

  // Entries without a valid bit read as their reset value
  assign cur_idx     = AW'(cur.id);
  assign st_cur      = st_vld[cur_idx] ? fstate_t'(st_rdata) : FS_FREE;
  assign fq_head_val = fq_vld[free_head] ? fq_rdata : ID_W'(free_head);

  assign fq_sum  = SW'(free_head) + SW'(free_fill);
  assign dq_sum  = SW'(disp_head) + SW'(disp_fill);
  assign fq_tail = (fq_sum >= SW'(POOL_DEPTH)) ? AW'(fq_sum - SW'(POOL_DEPTH)) : AW'(fq_sum);
  assign dq_tail = (dq_sum >= SW'(POOL_DEPTH)) ? AW'(dq_sum - SW'(POOL_DEPTH)) : AW'(dq_sum);

  assign free_full = (free_fill == FW'(POOL_DEPTH));
  assign disp_full = (disp_fill == FW'(POOL_DEPTH));
  assign free_head_inc = (free_head == AW'(POOL_DEPTH - 1)) ? '0 : free_head + AW'(1);
  assign disp_head_inc = (disp_head == AW'(POOL_DEPTH - 1)) ? '0 : disp_head + AW'(1);

  // Execute the held command
  always_comb begin
    free_head_next = free_head;
    free_fill_next = free_fill;
    disp_head_next = disp_head;
    disp_fill_next = disp_fill;
    flush      = 1'b0;
    res_frame  = '0;
    res_found  = 1'b0;
    res_status = STS_OK;
    st_we      = 1'b0;
    st_waddr   = cur_idx;
    st_wdata   = FS_FREE;
    fq_we      = 1'b0;
    fq_waddr   = fq_tail;
    dq_we      = 1'b0;
    dq_waddr   = dq_tail;
    if (exec) begin
      case (cur.kind)
        K_REQUEST: begin
          if (free_fill != '0) begin
            res_found      = 1'b1;
            res_frame      = fq_head_val;
            free_head_next = free_head_inc;
            free_fill_next = free_fill - FW'(1);
            st_we          = 1'b1;
            st_waddr       = AW'(fq_head_val);
            st_wdata       = FS_DECODING;
          end
        end
        K_RET_DECODED: begin
          if (st_cur == FS_DECODING && cur.valid_req) begin
            if (disp_full) begin
              res_status = STS_FULL;
            end else begin
              dq_we          = 1'b1;
              disp_fill_next = disp_fill + FW'(1);
              st_we          = 1'b1;
              st_wdata       = FS_DISPLAY;
            end
          end else if (st_cur == FS_DECODING || st_cur == FS_SHARED_FREE) begin
            if (free_full) begin
              res_status = STS_FULL;
            end else begin
              fq_we          = 1'b1;
              free_fill_next = free_fill + FW'(1);
              st_we          = 1'b1;
              st_wdata       = FS_FREE;
            end
          end else if (st_cur == FS_SHARED) begin
            st_we    = 1'b1;
            st_wdata = FS_DISPLAY;
          end
        end
        K_SHARE: begin
          if (disp_full) begin
            res_status = STS_FULL;
          end else begin
            dq_we          = 1'b1;
            disp_fill_next = disp_fill + FW'(1);
            st_we          = 1'b1;
            st_wdata       = FS_SHARED;
          end
        end
        K_GET_DISPLAY: begin
          if (disp_fill != '0) begin
            res_found      = 1'b1;
            res_frame      = dq_rdata;
            disp_head_next = disp_head_inc;
            disp_fill_next = disp_fill - FW'(1);
          end
        end
        K_RET_DISPLAY: begin
          if (st_cur == FS_DISPLAY) begin
            if (free_full) begin
              res_status = STS_FULL;
            end else begin
              fq_we          = 1'b1;
              free_fill_next = free_fill + FW'(1);
              st_we          = 1'b1;
              st_wdata       = FS_FREE;
            end
          end else if (st_cur == FS_SHARED) begin
            st_we    = 1'b1;
            st_wdata = FS_SHARED_FREE;
          end
        end
        K_FLUSH: begin
          flush          = 1'b1;
          free_head_next = '0;
          free_fill_next = eff_count;
          disp_head_next = '0;
          disp_fill_next = '0;
        end
        K_BAD_ID: res_status = STS_BAD_ID;
        default:  res_status = STS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= cmd;
    end
    if (exec) begin
      rsp_frame       <= res_frame;
      rsp_found       <= res_found;
      rsp_status      <= res_status;
      rsp_free_count  <= CNT_W'(free_fill_next);
      rsp_ready_count <= CNT_W'(disp_fill_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state  <= BK_IDLE;
      free_head <= '0;
      free_fill <= FW'(RST_FILL);
      disp_head <= '0;
      disp_fill <= '0;
      st_vld    <= '0;
      fq_vld    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      bk_state  <= bk_state_next;
      free_head <= free_head_next;
      free_fill <= free_fill_next;
      disp_head <= disp_head_next;
      disp_fill <= disp_fill_next;
      if (flush) begin
        st_vld <= '0;
        fq_vld <= '0;
      end else begin
        if (st_we) begin
          st_vld[st_waddr] <= 1'b1;
        end
        if (fq_we) begin
          fq_vld[fq_waddr] <= 1'b1;
        end
      end
      if (exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.out_frame   = rsp_frame;
  assign rsp.found       = rsp_found;
  assign rsp.status      = rsp_status;
  assign rsp.free_count  = rsp_free_count;
  assign rsp.ready_count = rsp_ready_count;

endmodule

/* rtl/core/frame_buffer_pool_manager_core.sv */
// Path: an accepted request passes the command queue, then the back end's idle
//   state (frame state read) and execute state, and then its response is registered.
// The back end takes a new command only from its idle state, so it does not take
//   one while the last is still executing on the frame state and queue memories.
// Reset (synchronous): pool of 16 frames, all free, free queue holds ids 0..15,
//   display queue empty. Valid bits clear at once, so no clearing pass is needed.
module frame_buffer_pool_manager_core #(
  parameter int POOL_DEPTH = fbp_pkg::DEF_POOL_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  fbp_in_if.sink    req,
  fbp_out_if.source rsp,
  fbp_cfg_if.sink   cfg
);
  import fbp_pkg::*;

  localparam int FW = $clog2(POOL_DEPTH + 1);

  // Front end to queue
  logic          cmd_push;
  cmd_t          front_cmd;
  logic          fifo_full;

  // Queue to back end
  logic          cmd_valid;
  logic          cmd_pop;
  cmd_t          head_cmd;

  // Effective pool size: frame count clamped to the storage depth
  logic [FW-1:0] eff_count;

  // Front end: take a request, check its frame id against the pool size and
  // classify it. It stalls only when the command queue is full.
  fbp_front #(.POOL_DEPTH(POOL_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd),
    .eff_count (eff_count)
  );

  // Command queue: decouple request acceptance from execution so a new
  // request is taken while a response waits on the output side.
  fbp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (front_cmd),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .head_cmd  (head_cmd)
  );

  // Back end: read frame state and queue heads, then update state, queues
  // and counts and load the response register. Hold a new command while the
  // response register is occupied and not being drained.
  fbp_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .eff_count (eff_count),
    .rsp       (rsp)
  );

endmodule
